### rtl/core/cke_pkg.sv
// ----------------------------------------------------------------------------
// cke_pkg
// Shared types and constants for the calculator key entry engine.
// ----------------------------------------------------------------------------
package cke_pkg;

  localparam int unsigned W       = 64;          // value width
  localparam int unsigned FB      = 20;          // fraction bits
  localparam int unsigned IW      = W - FB;      // integer part width
  localparam int unsigned NW      = W + FB;      // divider numerator width
  localparam int unsigned CW      = $clog2(NW + 1);
  localparam int unsigned LIMIT_W = 42;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 42'd100000000000;

  localparam logic [CW-1:0] CNT_MUL  = CW'(W);
  localparam logic [CW-1:0] CNT_DIV  = CW'(NW);
  localparam logic [CW-1:0] CNT_INT  = CW'(IW);
  localparam logic [CW-1:0] CNT_FRAC = CW'(FB);

  localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] TEN     = W'(10);

  localparam logic [7:0] KEY_CLEAR  = 8'd0;
  localparam logic [7:0] KEY_ADD    = 8'd1;
  localparam logic [7:0] KEY_SUB    = 8'd2;
  localparam logic [7:0] KEY_MUL    = 8'd3;
  localparam logic [7:0] KEY_DIV    = 8'd4;
  localparam logic [7:0] KEY_EQUAL  = 8'd5;
  localparam logic [7:0] KEY_NEGATE = 8'd6;
  localparam logic [7:0] KEY_MOD    = 8'd7;
  localparam logic [7:0] KEY_BKSP   = 8'd8;
  localparam logic [7:0] KEY_DIGIT_MAX = 8'd9;

  localparam logic [2:0] OP_ADD = 3'd1;
  localparam logic [2:0] OP_SUB = 3'd2;
  localparam logic [2:0] OP_MUL = 3'd3;
  localparam logic [2:0] OP_DIV = 3'd4;
  localparam logic [2:0] OP_MOD = 3'd7;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_OVF     = 3'd1;
  localparam logic [2:0] ERR_DIV0    = 3'd2;
  localparam logic [2:0] ERR_INVALID = 3'd3;
  localparam logic [2:0] ERR_MOD0    = 3'd4;

  localparam logic [1:0] RK_NONE  = 2'd0;
  localparam logic [1:0] RK_CLEAR = 2'd1;
  localparam logic [1:0] RK_CHAIN = 2'd2;

  typedef enum logic [1:0] {
    MODE_MUL = 2'b01,
    MODE_DIV = 2'b10
  } iter_mode_e;

  typedef struct packed {
    logic             start;
    iter_mode_e       mode;
    logic [CW-1:0]    count;
    logic [W-1:0]     opnd;   // multiplicand or divisor
    logic [W-1:0]     mult;   // multiplier
    logic [NW-1:0]    num;    // numerator, top aligned to count
  } iter_req_t;

  typedef struct packed {
    logic          done;
    logic [W-1:0]  hi;        // product high half / remainder
    logic [W-1:0]  lo;        // product low half
    logic [NW-1:0] quo;       // quotient in the low count bits
  } iter_rsp_t;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    mag_of = v[W-1] ? (W'(0) - v) : v;
  endfunction

  function automatic logic mag_fits(input logic neg, input logic [W-1:0] m);
    mag_fits = !m[W-1] || (neg && (m == MIN_NEG));
  endfunction

  function automatic logic [W-1:0] apply_sign(input logic neg, input logic [W-1:0] m);
    apply_sign = neg ? (W'(0) - m) : m;
  endfunction

endpackage

### rtl/core/cke_iter_unit.sv
// ----------------------------------------------------------------------------
// cke_iter_unit
// Shift-add multiplier and restoring divider on one shared 65-bit adder.
// ----------------------------------------------------------------------------
module cke_iter_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cke_pkg::iter_req_t req_i,
  output cke_pkg::iter_rsp_t rsp_o
);
  import cke_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  iter_mode_e       mode_q, mode_d;
  logic [W-1:0]     opnd_q, opnd_d;
  logic [W-1:0]     acc_q, acc_d;
  logic [W-1:0]     lo_q, lo_d;
  logic [NW-1:0]    num_q, num_d;

  logic [W:0]       x, y;
  logic             sub;
  logic [W+1:0]     sum;
  logic             ge;

  // shared adder
  always_comb begin
    if (mode_q == MODE_DIV) begin
      x   = {acc_q, num_q[NW-1]};
      y   = {1'b0, opnd_q};
      sub = 1'b1;
    end else begin
      x   = {1'b0, acc_q};
      y   = lo_q[0] ? {1'b0, opnd_q} : '0;
      sub = 1'b0;
    end
    sum = {1'b0, x} + {1'b0, (sub ? ~y : y)} + (W+2)'(sub);
    ge  = sum[W+1];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mode_d = mode_q;
    opnd_d = opnd_q;
    acc_d  = acc_q;
    lo_d   = lo_q;
    num_d  = num_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.count;
      mode_d = req_i.mode;
      opnd_d = req_i.opnd;
      acc_d  = '0;
      lo_d   = req_i.mult;
      num_d  = req_i.num;
    end else if (busy_q) begin
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
      if (mode_q == MODE_DIV) begin
        acc_d = ge ? sum[W-1:0] : x[W-1:0];
        num_d = {num_q[NW-2:0], ge};
      end else begin
        acc_d = sum[W:1];
        lo_d  = {sum[0], lo_q[W-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      mode_q <= MODE_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opnd_q <= opnd_d;
    acc_q  <= acc_d;
    lo_q   <= lo_d;
    num_q  <= num_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.hi   = acc_q;
  assign rsp_o.lo   = lo_q;
  assign rsp_o.quo  = num_q;

endmodule

### rtl/core/calculator_key_entry_engine.sv
// ----------------------------------------------------------------------------
// calculator_key_entry_engine
// Add, subtract, multiply, divide and modulo key engine on signed Q43.20 operands.
// ----------------------------------------------------------------------------
//
//  channel  | dir | transfer when            | payload
//  ---------+-----+--------------------------+------------------------------
//  s_axis   | in  | tvalid & tready          | tdata key value, tuser cmd
//  m_axis   | out | tvalid & tready          | tdata operands/result/status
//  cfg      | in  | cfg_we_i                 | overflow limit (42 bits)
//
//  Multiply, divide, modulo and backspace run on the shared iterative unit,
//  one product or quotient bit per cycle.
//  Reset is asynchronous; all calculator state returns to its clear value.
//  s_axis_tready is high only while the sequencer is idle. A finished
//  result waits in the output register; the next key is taken meanwhile and
//  its result is held back until the output register frees.
//
module calculator_key_entry_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] key_value
  input  logic                         s_axis_tuser,  // [0] cmd
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [63:0] first_value, [127:64] second_value, [191:128] result_value,
  // [192] result_valid, [195:193] pending_op, [196] editing_second,
  // [197] first_negative, [198] second_negative, [201:199] error_code,
  // [207:202] zero
  output logic [207:0]                 m_axis_tdata,
  input  logic                         cfg_we_i,
  input  logic [cke_pkg::LIMIT_W-1:0]  cfg_wdata_i
);
  import cke_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_DECODE  = 10'b0000000010,
    ST_DIG_MUL = 10'b0000000100,
    ST_DIG_ADD = 10'b0000001000,
    ST_EVAL    = 10'b0000010000,
    ST_WAIT    = 10'b0000100000,
    ST_POST    = 10'b0001000000,
    ST_FIN     = 10'b0010000000,
    ST_ERR     = 10'b0100000000,
    ST_EMIT    = 10'b1000000000
  } state_e;

  typedef enum logic [4:0] {
    PH_MUL = 5'b00001,
    PH_DIV = 5'b00010,
    PH_MOD = 5'b00100,
    PH_BS1 = 5'b01000,
    PH_BS2 = 5'b10000
  } phase_e;

  // calculator architectural state
  typedef struct packed {
    logic [W-1:0] first;
    logic         first_sign;
    logic [W-1:0] second;
    logic         second_sign;
    logic         sel;
    logic [2:0]   op;
    logic [W-1:0] result;
    logic         ready;
    logic [1:0]   rk;
  } arch_t;

  localparam arch_t ARCH_CLEAR = '{first: '0, first_sign: 1'b0, second: '0,
                                   second_sign: 1'b0, sel: 1'b0, op: OP_ADD,
                                   result: '0, ready: 1'b0, rk: RK_NONE};

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  arch_t             arch_q, arch_d;
  logic [LIMIT_W-1:0] limit_q;
  logic              cmd_q, cmd_d;
  logic [7:0]        key_q, key_d;
  logic [2:0]        err_q, err_d;
  logic              chain_q, chain_d;
  logic [W-1:0]      tmp_q, tmp_d;      // digit x10 value or eval result
  logic [IW-1:0]     qint_q, qint_d;    // backspace integer quotient
  logic              out_vld_q;
  logic [201:0]      out_q;

  iter_req_t         req;
  iter_rsp_t         rsp;

  cke_iter_unit u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // operand currently being edited
  logic [W-1:0]  cur, cur_mag, a_mag, b_mag;
  logic          cur_sgn, prod_neg;
  logic [W+3:0]  v10;
  logic [W-1:0]  dval, dsig, dsum, esum, ediff, nxt_mag;
  logic [W-1:0]  bs_mag;
  logic          out_free;

  always_comb begin
    cur      = arch_q.sel ? arch_q.second : arch_q.first;
    cur_sgn  = arch_q.sel ? arch_q.second_sign : arch_q.first_sign;
    cur_mag  = mag_of(cur);
    a_mag    = mag_of(arch_q.first);
    b_mag    = mag_of(arch_q.second);
    prod_neg = arch_q.first[W-1] ^ arch_q.second[W-1];
    // x10 as 8m + 2m
    v10      = {1'b0, cur_mag, 3'b0} + {3'b0, cur_mag, 1'b0};
    dval     = W'(key_q[3:0]) << FB;
    dsig     = cur_sgn ? (W'(0) - dval) : dval;
    dsum     = tmp_q + dsig;
    esum     = arch_q.first + arch_q.second;
    ediff    = arch_q.first - arch_q.second;
    nxt_mag  = mag_of(tmp_q);
    bs_mag   = {qint_q, rsp.quo[FB-1:0]};
    out_free = !out_vld_q || m_axis_tready;
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    arch_d  = arch_q;
    cmd_d   = cmd_q;
    key_d   = key_q;
    err_d   = err_q;
    chain_d = chain_q;
    tmp_d   = tmp_q;
    qint_d  = qint_q;
    req     = '{start: 1'b0, mode: MODE_DIV, count: CNT_DIV, opnd: TEN,
                mult: '0, num: '0};

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d   = s_axis_tuser;
          key_d   = s_axis_tdata;
          err_d   = ERR_NONE;
          chain_d = 1'b0;
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        if (!cmd_q) begin
          if (key_q > KEY_DIGIT_MAX) begin
            err_d   = ERR_INVALID;
            state_d = ST_ERR;
          end else begin
            if (arch_q.rk == RK_CLEAR) arch_d = ARCH_CLEAR;
            state_d = ST_DIG_MUL;
          end
        end else begin
          case (key_q)
            KEY_CLEAR: begin
              arch_d  = ARCH_CLEAR;
              state_d = ST_EMIT;
            end
            KEY_EQUAL: begin
              arch_d.rk = RK_CLEAR;
              state_d   = ST_EVAL;
            end
            KEY_NEGATE: begin
              if (arch_q.sel) begin
                arch_d.second_sign = !arch_q.second_sign;
                arch_d.second = (cur == MIN_NEG) ? MAX_POS : (W'(0) - cur);
              end else begin
                arch_d.first_sign = !arch_q.first_sign;
                arch_d.first = (cur == MIN_NEG) ? MAX_POS : (W'(0) - cur);
              end
              state_d = ST_EMIT;
            end
            KEY_BKSP: begin
              // integer part / 10 first, then fraction / 10
              req.start = 1'b1;
              req.count = CNT_INT;
              req.num   = {cur_mag[W-1:FB], {(2*FB){1'b0}}};
              phase_d   = PH_BS1;
              state_d   = ST_WAIT;
            end
            KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV, KEY_MOD: begin
              if (arch_q.rk == RK_CHAIN) begin
                chain_d = 1'b1;
                state_d = ST_EVAL;
              end else begin
                arch_d.op  = key_q[2:0];
                arch_d.sel = 1'b1;
                state_d    = ST_EMIT;
              end
            end
            default: begin
              err_d   = ERR_INVALID;
              state_d = ST_ERR;
            end
          endcase
        end
      end

      ST_DIG_MUL: begin
        if (cur_mag[W-1:FB] >= IW'(limit_q)) begin
          err_d   = ERR_OVF;
          state_d = ST_ERR;
        end else begin
          if (arch_q.sel) arch_d.rk = RK_CHAIN;
          if ((v10[W+3:W] != 4'b0) || !mag_fits(cur[W-1], v10[W-1:0])) begin
            err_d   = ERR_OVF;
            state_d = ST_ERR;
          end else begin
            tmp_d   = apply_sign(cur[W-1], v10[W-1:0]);
            state_d = ST_DIG_ADD;
          end
        end
      end

      ST_DIG_ADD: begin
        if ((tmp_q[W-1] == dsig[W-1]) && (dsum[W-1] != tmp_q[W-1])) begin
          err_d   = ERR_OVF;
          state_d = ST_ERR;
        end else begin
          if (arch_q.sel) arch_d.second = dsum;
          else            arch_d.first  = dsum;
          state_d = ST_EMIT;
        end
      end

      ST_EVAL: begin
        case (arch_q.op)
          OP_ADD: begin
            if (((arch_q.first ^ esum) & (arch_q.second ^ esum)) >> (W-1) != W'(0)) begin
              err_d   = ERR_OVF;
              state_d = ST_ERR;
            end else begin
              tmp_d   = esum;
              state_d = ST_FIN;
            end
          end
          OP_SUB: begin
            if (((arch_q.first ^ arch_q.second) & (arch_q.first ^ ediff)) >> (W-1)
                != W'(0)) begin
              err_d   = ERR_OVF;
              state_d = ST_ERR;
            end else begin
              tmp_d   = ediff;
              state_d = ST_FIN;
            end
          end
          OP_MUL: begin
            req.start = 1'b1;
            req.mode  = MODE_MUL;
            req.count = CNT_MUL;
            req.opnd  = a_mag;
            req.mult  = b_mag;
            phase_d   = PH_MUL;
            state_d   = ST_WAIT;
          end
          OP_DIV: begin
            if (b_mag == W'(0)) begin
              err_d   = ERR_DIV0;
              state_d = ST_ERR;
            end else begin
              req.start = 1'b1;
              req.opnd  = b_mag;
              req.num   = {a_mag, {FB{1'b0}}};
              phase_d   = PH_DIV;
              state_d   = ST_WAIT;
            end
          end
          OP_MOD: begin
            if (b_mag[W-1:FB] == IW'(0)) begin
              err_d   = ERR_MOD0;
              state_d = ST_ERR;
            end else begin
              req.start = 1'b1;
              req.count = CNT_INT;
              req.opnd  = W'(b_mag[W-1:FB]);
              req.num   = {a_mag[W-1:FB], {(2*FB){1'b0}}};
              phase_d   = PH_MOD;
              state_d   = ST_WAIT;
            end
          end
          default: begin
            tmp_d   = arch_q.result;
            state_d = ST_FIN;
          end
        endcase
      end

      ST_WAIT: begin
        if (rsp.done) state_d = ST_POST;
      end

      ST_POST: begin
        case (phase_q)
          PH_MUL: begin
            if ((rsp.hi[W-1:FB] != IW'(0)) ||
                !mag_fits(prod_neg, {rsp.hi[FB-1:0], rsp.lo[W-1:FB]})) begin
              err_d   = ERR_OVF;
              state_d = ST_ERR;
            end else begin
              tmp_d   = apply_sign(prod_neg, {rsp.hi[FB-1:0], rsp.lo[W-1:FB]});
              state_d = ST_FIN;
            end
          end
          PH_DIV: begin
            if ((rsp.quo[NW-1:W] != FB'(0)) || !mag_fits(prod_neg, rsp.quo[W-1:0])) begin
              err_d   = ERR_OVF;
              state_d = ST_ERR;
            end else begin
              tmp_d   = apply_sign(prod_neg, rsp.quo[W-1:0]);
              state_d = ST_FIN;
            end
          end
          PH_MOD: begin
            if (!mag_fits(arch_q.first[W-1], {rsp.hi[IW-1:0], {FB{1'b0}}})) begin
              err_d   = ERR_OVF;
              state_d = ST_ERR;
            end else begin
              tmp_d   = apply_sign(arch_q.first[W-1], {rsp.hi[IW-1:0], {FB{1'b0}}});
              state_d = ST_FIN;
            end
          end
          PH_BS1: begin
            qint_d    = rsp.quo[IW-1:0];
            req.start = 1'b1;
            req.count = CNT_FRAC;
            req.num   = {cur_mag[FB-1:0], {W{1'b0}}};
            phase_d   = PH_BS2;
            state_d   = ST_WAIT;
          end
          default: begin
            // backspace: magnitude shrinks, so the sign always fits
            if (arch_q.sel) arch_d.second = apply_sign(cur[W-1], bs_mag);
            else            arch_d.first  = apply_sign(cur[W-1], bs_mag);
            state_d = ST_EMIT;
          end
        endcase
      end

      ST_FIN: begin
        arch_d.result = tmp_q;
        arch_d.ready  = 1'b1;
        state_d       = ST_EMIT;
        if (chain_q) begin
          arch_d.first = tmp_q;
          if (nxt_mag[W-1:FB] >= IW'(limit_q)) begin
            err_d   = ERR_OVF;
            state_d = ST_ERR;
          end else begin
            arch_d.second      = '0;
            arch_d.second_sign = 1'b0;
            arch_d.result      = '0;
            arch_d.ready       = 1'b0;
            arch_d.rk          = RK_NONE;
            arch_d.op          = key_q[2:0];
            arch_d.sel         = 1'b1;
          end
        end
      end

      ST_ERR: begin
        arch_d  = ARCH_CLEAR;
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_MUL;
      arch_q    <= ARCH_CLEAR;
      limit_q   <= LIMIT_RESET;
      out_vld_q <= 1'b0;
      chain_q   <= 1'b0;
      err_q     <= ERR_NONE;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      arch_q  <= arch_d;
      chain_q <= chain_d;
      err_q   <= err_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if ((state_q == ST_EMIT) && out_free) out_vld_q <= 1'b1;
      else if (m_axis_tready)               out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    key_q  <= key_d;
    tmp_q  <= tmp_d;
    qint_q <= qint_d;
    if ((state_q == ST_EMIT) && out_free) begin
      out_q <= {err_q, arch_q.second_sign, arch_q.first_sign, arch_q.sel, arch_q.op,
                arch_q.ready, arch_q.result, arch_q.second, arch_q.first};
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_q};

  // an accepted key always goes straight to decode
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_DECODE))
    else $error("accepted key did not reach decode");

  // the iterative unit only reports back while the sequencer waits on it
  a_iter_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (state_q == ST_WAIT))
    else $error("iterative unit finished outside wait state");

  // second operand stays clear until an operator selects it
  a_second_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !arch_q.sel |-> ((arch_q.second == '0) && !arch_q.second_sign))
    else $error("second operand touched while first is selected");

  // an error result always carries cleared state
  a_err_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_q[201:199] != ERR_NONE)) |->
      ((out_q[191:0] == '0) && (out_q[195:193] == OP_ADD)))
    else $error("error result with live state");

endmodule

### test/calculator_key_entry_engine_tb.sv
// ----------------------------------------------------------------------------
// calculator_key_entry_engine_tb
// Self-checking testbench for the calculator key entry engine: directed key
// sequences for the corner cases, then random key sequences under several
// overflow limits, with random stalls on both streams.
// ----------------------------------------------------------------------------
module calculator_key_entry_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cke_pkg::*;

  // Expected display state for every key, in transfer order.
  class calc_scoreboard;
    logic [63:0]        first_q, second_q, result_q;
    logic               first_neg, second_neg, editing, ready;
    logic [2:0]         oper;
    logic [1:0]         rkind;
    logic [LIMIT_W-1:0] limit;
    logic [207:0]       expected_q[$];
    int                 mismatches, keys_seen, results_seen;
    int                 err_hist[5];

    function void clear_calc();
      first_q = '0; second_q = '0; result_q = '0;
      first_neg = 0; second_neg = 0; editing = 0; ready = 0;
      oper = OP_ADD; rkind = RK_NONE;
    endfunction

    function void reset_calc();
      limit = LIMIT_RESET;
      clear_calc();
    endfunction

    function logic [63:0] mag(logic [63:0] v);
      return v[63] ? -v : v;
    endfunction

    // Apply a sign to a magnitude; fails when it leaves the 64-bit range.
    function bit signed_val(bit neg, logic [63:0] m, output logic [63:0] v);
      v = neg ? -m : m;
      return !(m > MAX_POS + 64'(neg));
    endfunction

    function bit add_ok(logic [63:0] a, logic [63:0] b, output logic [63:0] s);
      s = a + b;
      return !(((a ^ s) & (b ^ s)) >> 63);
    endfunction

    function bit sub_ok(logic [63:0] a, logic [63:0] b, output logic [63:0] s);
      s = a - b;
      return !(((a ^ b) & (a ^ s)) >> 63);
    endfunction

    function logic [2:0] evaluate();
      logic [63:0]  ma, mb, r, q;
      logic [127:0] prod;
      logic [83:0]  quo;
      bit           neg;
      ma = mag(first_q); mb = mag(second_q); r = result_q;
      neg = first_q[63] ^ second_q[63];
      case (oper)
        OP_ADD: if (!add_ok(first_q, second_q, r)) return ERR_OVF;
        OP_SUB: if (!sub_ok(first_q, second_q, r)) return ERR_OVF;
        OP_MUL: begin
          prod = {64'd0, ma} * {64'd0, mb};
          if (prod[127:84] != 0) return ERR_OVF;
          if (!signed_val(neg, prod[83:20], r)) return ERR_OVF;
        end
        OP_DIV: begin
          if (mb == 0) return ERR_DIV0;
          quo = {ma, 20'd0} / {20'd0, mb};
          if (quo[83:64] != 0) return ERR_OVF;
          if (!signed_val(neg, quo[63:0], r)) return ERR_OVF;
        end
        OP_MOD: begin
          if ((mb >> FB) == 0) return ERR_MOD0;
          q = ((ma >> FB) % (mb >> FB)) << FB;
          if (!signed_val(first_q[63], q, r)) return ERR_OVF;
        end
        default: ;
      endcase
      result_q = r;
      ready = 1;
      return ERR_NONE;
    endfunction

    function logic [2:0] digit_key(logic [7:0] key);
      logic [63:0] t, m, v10, d, nv;
      bit          sgn;
      if (key > KEY_DIGIT_MAX) return ERR_INVALID;
      if (rkind == RK_CLEAR) clear_calc();
      t = editing ? second_q : first_q;
      sgn = editing ? second_neg : first_neg;
      m = mag(t);
      if ((m >> FB) >= 64'(limit)) return ERR_OVF;
      if (editing) rkind = RK_CHAIN;
      if (m > (~64'd0) / 10 || !signed_val(t[63], m * 10, v10)) return ERR_OVF;
      d = 64'(key) << FB;
      if (!add_ok(v10, sgn ? -d : d, nv)) return ERR_OVF;
      if (editing) second_q = nv; else first_q = nv;
      return ERR_NONE;
    endfunction

    function logic [2:0] op_key(logic [7:0] key);
      logic [63:0] t, m, nv;
      logic [2:0]  e;
      t = editing ? second_q : first_q;
      m = mag(t);
      case (key)
        KEY_CLEAR: clear_calc();
        KEY_EQUAL: begin
          rkind = RK_CLEAR;
          return evaluate();
        end
        KEY_NEGATE: begin
          if (editing) second_neg = !second_neg; else first_neg = !first_neg;
          // most negative value saturates to the largest positive one
          if (!signed_val(!t[63] && t != 0, m, nv)) nv = MAX_POS;
          if (editing) second_q = nv; else first_q = nv;
        end
        KEY_BKSP: begin
          m = (m - (((m >> FB) % 10) << FB)) / 10;
          void'(signed_val(t[63], m, nv));
          if (editing) second_q = nv; else first_q = nv;
        end
        KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV, KEY_MOD: begin
          if (rkind == RK_CHAIN) begin
            e = evaluate();
            if (e != ERR_NONE) return e;
            first_q = result_q;
            if ((mag(first_q) >> FB) >= 64'(limit)) return ERR_OVF;
            second_q = '0; second_neg = 0;
            result_q = '0; ready = 0; rkind = RK_NONE;
          end
          oper = key[2:0];
          editing = 1;
        end
        default: return ERR_INVALID;
      endcase
      return ERR_NONE;
    endfunction

    function void note_key(logic cmd, logic [7:0] key);
      logic [2:0] err;
      err = cmd ? op_key(key) : digit_key(key);
      if (err != ERR_NONE) clear_calc();
      err_hist[err]++;
      keys_seen++;
      expected_q.push_back({6'd0, err, second_neg, first_neg, editing, oper, ready,
                            result_q, second_q, first_q});
    endfunction

    function void report(string name, logic [63:0] exp_v, logic [63:0] act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH result %0d %s: expected %h, got %h",
                 results_seen, name, exp_v, act_v);
    endfunction

    function void check_result(logic [207:0] act);
      logic [207:0] exp_v;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("MISMATCH result %0d with nothing pending", results_seen);
        return;
      end
      exp_v = expected_q.pop_front();
      if (exp_v[63:0]    != act[63:0])    report("first_value",  exp_v[63:0],    act[63:0]);
      if (exp_v[127:64]  != act[127:64])  report("second_value", exp_v[127:64],  act[127:64]);
      if (exp_v[191:128] != act[191:128]) report("result_value", exp_v[191:128], act[191:128]);
      if (exp_v[192]     != act[192])     report("result_valid", exp_v[192],     act[192]);
      if (exp_v[195:193] != act[195:193]) report("pending_op",   exp_v[195:193], act[195:193]);
      if (exp_v[196]     != act[196])     report("editing_second", exp_v[196],   act[196]);
      if (exp_v[197]     != act[197])     report("first_negative", exp_v[197],   act[197]);
      if (exp_v[198]     != act[198])     report("second_negative", exp_v[198],  act[198]);
      if (exp_v[201:199] != act[201:199]) report("error_code",   exp_v[201:199], act[201:199]);
      if (exp_v[207:202] != act[207:202]) report("padding",      exp_v[207:202], act[207:202]);
    endfunction
  endclass

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 200;      // longer than the slowest key (divide) plus held result
  localparam int LONG_HOLD    = 400;

  logic               clk_i, rst_ni;
  logic               s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [7:0]         s_axis_tdata;
  logic               m_axis_tvalid, m_axis_tready;
  logic [207:0]       m_axis_tdata;
  logic               cfg_we_i;
  logic [LIMIT_W-1:0] cfg_wdata_i;

  calc_scoreboard calc_sb;
  bit             stall_en;     // random idling on both sides
  int             hold_left;    // long receiver hold-off, counted down per cycle
  int             cycles;

  calculator_key_entry_engine i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_wdata_i
  );

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // Transfers on both streams are taken at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) calc_sb.note_key(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) calc_sb.check_result(m_axis_tdata);
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request.
  initial begin
    int burst;
    m_axis_tready = 0;
    burst = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 0;
      end else if (burst > 0) begin
        burst--;
        m_axis_tready = 0;
      end else if (stall_en && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 4);
        m_axis_tready = 0;
      end else begin
        m_axis_tready = 1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycles,
               calc_sb.expected_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // One key transfer; drive at the falling edge, hold until accepted.
  task automatic press(logic cmd, logic [7:0] key);
    if (stall_en && $urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    s_axis_tvalid = 1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = key;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid = 0;
  endtask

  task automatic type_number(logic [63:0] num);
    string s;
    s = $sformatf("%0d", num);
    foreach (s[i]) press(0, 8'(s[i] - "0"));
  endtask

  // Wait until every result is in and the block is surely idle.
  task automatic drain();
    while (calc_sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_limit(logic [LIMIT_W-1:0] lim);
    drain();
    cfg_we_i = 1;
    cfg_wdata_i = lim;
    @(negedge clk_i);
    cfg_we_i = 0;
    calc_sb.limit = lim;
  endtask

  // Random key, weighted toward well-formed calculator use.
  task automatic random_key();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) press(0, 8'($urandom_range(0, 9)));
    else if (pick < 73) press(1, 8'($urandom_range(1, 4)));
    else if (pick < 77) press(1, KEY_MOD);
    else if (pick < 85) press(1, KEY_EQUAL);
    else if (pick < 89) press(1, KEY_NEGATE);
    else if (pick < 93) press(1, KEY_BKSP);
    else if (pick < 95) press(1, KEY_CLEAR);
    else if (pick < 97) press(0, 8'($urandom_range(10, 255)));
    else press(1, 8'($urandom_range(9, 255)));
  endtask

  initial begin
    logic [LIMIT_W-1:0] limits[5];
    calc_sb = new();
    calc_sb.reset_calc();
    rst_ni = 0;
    s_axis_tvalid = 0; s_axis_tuser = 0; s_axis_tdata = '0;
    cfg_we_i = 0; cfg_wdata_i = '0;
    stall_en = 0; hold_left = 0; cycles = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed: plain arithmetic on every operator.
    type_number(12); press(1, KEY_ADD); type_number(34); press(1, KEY_MUL);
    type_number(3);  press(1, KEY_SUB); press(1, KEY_NEGATE); type_number(7);
    press(1, KEY_DIV); type_number(4); press(1, KEY_MOD); type_number(5);
    press(1, KEY_EQUAL); press(1, KEY_BKSP);
    // Zero divisor and zero-integer modulo divisor.
    press(1, KEY_DIV); press(1, KEY_EQUAL);
    press(0, 8'd9); press(1, KEY_MOD); press(1, KEY_EQUAL);
    // Invalid digit and op code, at both ends of the invalid key range.
    press(0, 8'd10); press(0, 8'hFF); press(1, 8'd9); press(1, 8'hFF);
    press(1, KEY_CLEAR);

    // Largest limit: reach the most negative value, then negate it.
    set_limit({LIMIT_W{1'b1}});
    press(1, KEY_NEGATE); type_number(64'd8796093022208); press(1, KEY_NEGATE);
    press(0, 8'd1);
    // Limit zero: any digit overflows.
    set_limit('0);
    press(0, 8'd0); press(1, KEY_ADD);
    // Smallest non-zero limit.
    set_limit(42'd1);
    press(0, 8'd5); press(0, 8'd5); press(1, KEY_EQUAL);

    // Random phases under different limits.
    limits = '{LIMIT_RESET, 42'd1000, {LIMIT_W{1'b1}}, 42'd1, LIMIT_RESET};
    stall_en = 1;
    foreach (limits[p]) begin
      set_limit(limits[p]);   // drain here also pauses the sender
      for (int k = 0; k < 240; k++) begin
        if (p == 1 && k == 50) hold_left = LONG_HOLD;
        if (p == 4 && k == 120) stall_en = 0;    // last stretch without idling
        random_key();
      end
    end

    drain();
    $display("Covered %0d keys, %0d results, limits from 0 to max.",
             calc_sb.keys_seen, calc_sb.results_seen);
    $display("Errors seen: ovf %0d, div0 %0d, invalid %0d, mod0 %0d.",
             calc_sb.err_hist[ERR_OVF], calc_sb.err_hist[ERR_DIV0],
             calc_sb.err_hist[ERR_INVALID], calc_sb.err_hist[ERR_MOD0]);
    if (calc_sb.mismatches == 0 && calc_sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", calc_sb.mismatches,
               calc_sb.expected_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
